/* rtl/icv_pkg.sv */
// Shared types, constants and helper functions for the icosphere vertex generator.
// Used by every file in rtl; depends on nothing.
package icv_pkg;

    // Fraction bits of the output coordinates
    localparam int FRAC_BITS = 14;

    // Field widths
    localparam int DET_W   = 7;
    localparam int STRIP_W = 3;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 8;
    localparam int SLOT_W  = 16;
    localparam int POS_W   = 16;

    // Datapath widths
    localparam int WGT_W    = 10;              // barycentric weights, signed
    localparam int CRN_W    = 18;              // corner coordinates, signed, x2^16
    localparam int PRD_W    = 28;              // weight * corner
    localparam int VEC_W    = 28;              // unnormalized vector component
    localparam int MAG_W    = VEC_W - 1;       // magnitude of a component
    localparam int SQ_W     = 2 * VEC_W;       // squared length
    localparam int ROOT_W   = SQ_W / 2;        // integer square root
    localparam int SQ_REM_W = ROOT_W + 1;      // square root partial remainder
    localparam int Q_W      = FRAC_BITS + 1;   // quotient bits
    localparam int NUM_W    = MAG_W + FRAC_BITS + 1;

    localparam int ONE_Q = 1 << FRAC_BITS;

    // Input queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Icosahedron corner scaling
    localparam logic signed [CRN_W-1:0] CORNER_ONE = CRN_W'(65536);
    localparam logic signed [CRN_W-1:0] CORNER_PHI = CRN_W'(106039);

    // Corner codes: north ring, south ring, poles
    typedef enum logic [3:0] {
        CRN_RN0 = 4'd0,
        CRN_RN1 = 4'd1,
        CRN_RN2 = 4'd2,
        CRN_RN3 = 4'd3,
        CRN_RN4 = 4'd4,
        CRN_RS0 = 4'd5,
        CRN_RS1 = 4'd6,
        CRN_RS2 = 4'd7,
        CRN_RS3 = 4'd8,
        CRN_RS4 = 4'd9,
        CRN_PN  = 4'd10,
        CRN_PS  = 4'd11
    } corner_code_t;

    typedef struct packed {
        logic signed [CRN_W-1:0] x;
        logic signed [CRN_W-1:0] y;
        logic signed [CRN_W-1:0] z;
    } corner_t;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic signed [WGT_W-1:0] wgt0;
        logic signed [WGT_W-1:0] wgt1;
        logic signed [WGT_W-1:0] wgt2;
        corner_code_t            crn0;
        corner_code_t            crn1;
        corner_code_t            crn2;
    } work_t;

    // Sideband carried through the square root
    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic signed [VEC_W-1:0] vec_x;
        logic signed [VEC_W-1:0] vec_y;
        logic signed [VEC_W-1:0] vec_z;
    } side_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Corner table
    function automatic corner_t corner_of(corner_code_t code);
        corner_t c;
        c = '0;
        unique case (code)
            CRN_RN0: c = '{x: '0,          y: -CORNER_ONE, z: CORNER_PHI};
            CRN_RN1: c = '{x: CORNER_PHI,  y: '0,          z: CORNER_ONE};
            CRN_RN2: c = '{x: CORNER_ONE,  y: CORNER_PHI,  z: '0};
            CRN_RN3: c = '{x: -CORNER_ONE, y: CORNER_PHI,  z: '0};
            CRN_RN4: c = '{x: -CORNER_PHI, y: '0,          z: CORNER_ONE};
            CRN_RS0: c = '{x: -CORNER_ONE, y: -CORNER_PHI, z: '0};
            CRN_RS1: c = '{x: CORNER_ONE,  y: -CORNER_PHI, z: '0};
            CRN_RS2: c = '{x: CORNER_PHI,  y: '0,          z: -CORNER_ONE};
            CRN_RS3: c = '{x: '0,          y: CORNER_ONE,  z: -CORNER_PHI};
            CRN_RS4: c = '{x: -CORNER_PHI, y: '0,          z: -CORNER_ONE};
            CRN_PN:  c = '{x: '0,          y: CORNER_ONE,  z: CORNER_PHI};
            CRN_PS:  c = '{x: '0,          y: -CORNER_ONE, z: -CORNER_PHI};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Ring corner codes for a strip number 0..4
    function automatic corner_code_t ring_n(logic [STRIP_W-1:0] k);
        return corner_code_t'(4'(CRN_RN0) + {1'b0, k});
    endfunction

    function automatic corner_code_t ring_s(logic [STRIP_W-1:0] k);
        return corner_code_t'(4'(CRN_RS0) + {1'b0, k});
    endfunction

    // Signed output with saturation at the field limits
    function automatic logic [POS_W-1:0] scale_out(logic neg, logic [Q_W-1:0] q);
        logic [31:0]      qe;
        logic [POS_W-1:0] res;
        qe = 32'(q);
        if (neg)
            res = (qe > 32'd32768) ? 16'h8000 : POS_W'(-qe);
        else
            res = (qe > 32'd32767) ? 16'h7FFF : POS_W'(qe);
        return res;
    endfunction

endpackage

/* rtl/icv_if.sv */
// Channel interfaces of the icosphere vertex generator: points in, vertices out,
// detail register write. Depends on icv_pkg.
interface icv_point_if import icv_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STRIP_W-1:0] strip_index;
    logic [COL_W-1:0]   column_index;
    logic [ROW_W-1:0]   row_index;

    modport source (output valid, output strip_index, output column_index,
                    output row_index, input ready);
    modport sink   (input valid, input strip_index, input column_index,
                    input row_index, output ready);
endinterface

interface icv_vertex_if import icv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [SLOT_W-1:0]       vertex_slot;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, output vertex_slot, output pos_x, output pos_y,
                    output pos_z, input ready);
    modport sink   (input valid, input vertex_slot, input pos_x, input pos_y,
                    input pos_z, output ready);
endinterface

interface icv_cfg_if import icv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DET_W-1:0] detail;

    modport source (output valid, output detail, input ready);
    modport sink   (input valid, input detail, output ready);
endinterface

/* rtl/icosphere_vertex_generator.sv */
// Top level of the icosphere vertex generator: front end, item queue, back end.
// Depends on icv_pkg, icv_if, icv_front, icv_queue, icv_back.
//
// Each point item (strip, column, row) gives one vertex item: its buffer slot
// and its position on the unit sphere in signed Q1.14. The block takes one
// point per cycle while the queue has room and delivers one vertex per cycle
// while the vertex side is ready; between them lie the 28-stage square root,
// the 15-stage dividers and six blend, numerator and output stages. A four-item
// queue sits between the classifying front end and the arithmetic back end;
// when the vertex side stalls, the back end holds and the queue keeps taking
// points until it fills. The detail register may be written at any time the
// block is idle; it resets to 1.
module icosphere_vertex_generator import icv_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    icv_cfg_if.sink      cfg,
    icv_point_if.sink    point,
    icv_vertex_if.source vertex
);

    logic    push, pop;
    work_t   work_in, work_out;
    q_stat_t q_stat;

    icv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .point  (point),
        .q_stat (q_stat),
        .push   (push),
        .work   (work_in)
    );

    icv_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (work_in),
        .pop     (pop),
        .rd_data (work_out),
        .stat    (q_stat)
    );

    icv_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (work_out),
        .q_stat (q_stat),
        .pop    (pop),
        .vertex (vertex)
    );

    // The queue fills only through an accepted point
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_stat.full) |-> $past(push))
        else $error("queue became full without a push");

    // The queue leaves empty only through an accepted point
    a_fill_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(q_stat.empty) |-> $past(point.valid && point.ready))
        else $error("queue filled without an accepted point");

    // Normalized coordinates stay within the unit range
    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid |-> (FRAC_BITS > 14) ||
        ((int'(vertex.pos_x) <= ONE_Q) && (int'(vertex.pos_x) >= -ONE_Q) &&
         (int'(vertex.pos_y) <= ONE_Q) && (int'(vertex.pos_y) >= -ONE_Q) &&
         (int'(vertex.pos_z) <= ONE_Q) && (int'(vertex.pos_z) >= -ONE_Q)))
        else $error("vertex coordinate beyond unit length");

endmodule

/* rtl/icv_front.sv */
// Front end: detail register, point acceptance, slot computation and region
// classification into weights and corner codes. Depends on icv_pkg, icv_if.
module icv_front import icv_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    icv_cfg_if.sink    cfg,
    icv_point_if.sink  point,
    input  q_stat_t    q_stat,
    output logic       push,
    output work_t      work
);

    logic [DET_W-1:0]   detail_reg;
    logic [STRIP_W-1:0] strip_m5, strip_prv, strip_nxt, s_a, s_b;
    logic [COL_W-1:0]   col_eff;
    logic [9:0]         d_times_strip;
    logic [9:0]         col_sum;
    logic [8:0]         row_pitch;
    logic [SLOT_W-1:0]  slot_val;
    logic               row_low, moved;
    logic signed [WGT_W-1:0] rs, ds, cs, c1, c2;

    // Detail register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            detail_reg <= DET_W'(1);
        else if (cfg.valid)
            detail_reg <= cfg.detail;
    end

    // Accept while the queue has room
    assign point.ready = !q_stat.full;
    assign push        = point.valid && point.ready;

    // Strip modulo 5 and neighbors
    always_comb
    begin
        strip_m5  = (point.strip_index >= 3'd5) ? point.strip_index - 3'd5
                                                : point.strip_index;
        strip_prv = (strip_m5 == 3'd0) ? 3'd4 : strip_m5 - 3'd1;
        strip_nxt = (strip_m5 == 3'd4) ? 3'd0 : strip_m5 + 3'd1;
    end

    // Slot: row + (3d+1)*(col + d*strip), modulo 2^16
    always_comb
    begin
        case (strip_m5)
            3'd1:    d_times_strip = 10'(detail_reg);
            3'd2:    d_times_strip = 10'({detail_reg, 1'b0});
            3'd3:    d_times_strip = 10'(detail_reg) + 10'({detail_reg, 1'b0});
            3'd4:    d_times_strip = 10'({detail_reg, 2'b00});
            default: d_times_strip = '0;
        endcase
        row_pitch = 9'({detail_reg, 1'b0}) + 9'(detail_reg) + 9'd1;
        col_sum   = 10'(point.column_index) + d_times_strip;
        slot_val  = SLOT_W'(SLOT_W'(row_pitch) * SLOT_W'(col_sum))
                  + SLOT_W'(point.row_index);
    end

    // Column 0 of the lower third belongs to the previous strip
    always_comb
    begin
        row_low = point.row_index >= {detail_reg, 1'b0};
        moved   = row_low && (point.column_index == '0);
        s_a     = moved ? strip_prv : strip_m5;
        s_b     = moved ? strip_m5  : strip_nxt;
        col_eff = moved ? detail_reg : point.column_index;
    end

    // Region select and weights
    always_comb
    begin
        work.slot = slot_val;
        rs = WGT_W'(point.row_index);
        ds = WGT_W'(detail_reg);
        cs = WGT_W'(col_eff);
        if (point.row_index <= {1'b0, detail_reg})
        begin
            // north cap
            c1        = ds - rs;
            c2        = cs;
            work.crn0 = ring_n(s_a);
            work.crn1 = CRN_PN;
            work.crn2 = ring_n(s_b);
        end
        else if (row_low)
        begin
            // south cap
            c1        = rs - {ds[WGT_W-2:0], 1'b0};
            c2        = ds - cs;
            work.crn0 = ring_s(s_b);
            work.crn1 = CRN_PS;
            work.crn2 = ring_s(s_a);
        end
        else if (9'(point.row_index) <= 9'(detail_reg) + 9'(col_eff))
        begin
            // middle band, upper triangle
            c1        = rs - ds;
            c2        = ds - cs;
            work.crn0 = ring_n(s_b);
            work.crn1 = ring_s(s_b);
            work.crn2 = ring_n(s_a);
        end
        else
        begin
            // middle band, lower triangle
            c1        = cs;
            c2        = {ds[WGT_W-2:0], 1'b0} - rs;
            work.crn0 = ring_s(s_a);
            work.crn1 = ring_s(s_b);
            work.crn2 = ring_n(s_a);
        end
        work.wgt0 = ds - c1 - c2;
        work.wgt1 = c1;
        work.wgt2 = c2;
    end

endmodule

/* rtl/icv_queue.sv */
// Short FIFO of classified items between the front and the back end.
// Depends on icv_pkg.
module icv_queue import icv_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  work_t   wr_data,
    input  logic    pop,
    output work_t   rd_data,
    output q_stat_t stat
);

    work_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = count_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;

endmodule

/* rtl/icv_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on icv_pkg.
module icv_sqrt import icv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SQ_W-1:0]   sum_sq,
    input  side_t             side_in,
    output logic              out_vld,
    output logic [ROOT_W-1:0] root,
    output side_t             side_out
);

    logic [SQ_REM_W-1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];
    logic [SQ_W-1:0]     rad_reg  [ROOT_W];
    side_t               side_reg [ROOT_W];
    logic [ROOT_W-1:0]   vld_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [SQ_REM_W-1:0] rem_i;
        logic [ROOT_W-1:0]   root_i;
        logic [SQ_W-1:0]     rad_i;
        side_t               side_i;
        logic                vld_i;
        logic [SQ_REM_W+1:0] rem_sh, trial;
        logic                fits;

        if (k == 0)
        begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign rad_i  = sum_sq;
            assign side_i = side_in;
            assign vld_i  = in_vld;
        end
        else
        begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
            assign rad_i  = rad_reg[k-1];
            assign side_i = side_reg[k-1];
            assign vld_i  = vld_reg[k-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_i, rad_i[SQ_W-1 -: 2]};
        assign trial  = (SQ_REM_W+2)'({root_i, 2'b01});
        assign fits   = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= SQ_REM_W'(fits ? rem_sh - trial : rem_sh);
                root_reg[k] <= {root_i[ROOT_W-2:0], fits};
                rad_reg[k]  <= rad_i << 2;
                side_reg[k] <= side_i;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_i;
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

/* rtl/icv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, numerator over root.
// Depends on icv_pkg.
module icv_div import icv_pkg::*; (
    input  logic              clk,
    input  logic              en,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [Q_W-1:0]    quo
);

    logic [ROOT_W-1:0] rem_reg [Q_W];
    logic [ROOT_W-1:0] den_reg [Q_W];
    logic [Q_W-1:0]    low_reg [Q_W];
    logic [Q_W-1:0]    quo_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        logic [ROOT_W-1:0] rem_i, den_i;
        logic [Q_W-1:0]    low_i, quo_i;
        logic [ROOT_W:0]   rem_sh;
        logic              fits;

        if (k == 0)
        begin : g_first
            // upper numerator bits are below the divisor
            assign rem_i = ROOT_W'(num[NUM_W-1:Q_W]);
            assign low_i = num[Q_W-1:0];
            assign den_i = den;
            assign quo_i = '0;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[k-1];
            assign low_i = low_reg[k-1];
            assign den_i = den_reg[k-1];
            assign quo_i = quo_reg[k-1];
        end

        assign rem_sh = {rem_i, low_i[Q_W-1]};
        assign fits   = rem_sh >= {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ROOT_W'(fits ? rem_sh - {1'b0, den_i} : rem_sh);
                low_reg[k] <= low_i << 1;
                den_reg[k] <= den_i;
                quo_reg[k] <= {quo_i[Q_W-2:0], fits};
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

/* rtl/icv_back.sv */
// Back end: corner blend, squared length, square root, three dividers and the
// output register. Depends on icv_pkg, icv_if, icv_sqrt, icv_div.
module icv_back import icv_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  work_t        head,
    input  q_stat_t      q_stat,
    output logic         pop,
    icv_vertex_if.source vertex
);

    logic adv;

    // Blend stage
    corner_t                 crn      [3];
    logic signed [WGT_W-1:0] wgt      [3];
    logic signed [PRD_W-1:0] px_reg   [3];
    logic signed [PRD_W-1:0] py_reg   [3];
    logic signed [PRD_W-1:0] pz_reg   [3];
    logic [SLOT_W-1:0]       slot1_reg;
    logic                    vld1_reg;

    // Sum, square, length stages
    side_t           side2_reg, side3_reg, side4_reg;
    logic            vld2_reg, vld3_reg, vld4_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg, sum_sq_reg;

    // Square root output
    logic              rt_vld;
    logic [ROOT_W-1:0] rt_root;
    side_t             rt_side;

    // Numerator stage
    logic [NUM_W-1:0]  numx_reg, numy_reg, numz_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [2:0]        neg_reg;
    logic              zero_reg;
    logic [SLOT_W-1:0] slot5_reg;
    logic              vld5_reg;

    // Sideband alongside the dividers
    logic [SLOT_W-1:0] dslot_reg [Q_W];
    logic [2:0]        dneg_reg  [Q_W];
    logic [Q_W-1:0]    dzero_reg;
    logic [Q_W-1:0]    dvld_reg;
    logic [Q_W-1:0]    qx, qy, qz;

    // Output register
    logic                    out_vld_reg;
    logic [SLOT_W-1:0]       out_slot_reg;
    logic [POS_W-1:0]        out_x_reg, out_y_reg, out_z_reg;

    // Whole back end moves when the output register can take a new item
    assign adv = !out_vld_reg || vertex.ready;
    assign pop = adv && !q_stat.empty;

    always_comb
    begin
        crn[0] = corner_of(head.crn0);
        crn[1] = corner_of(head.crn1);
        crn[2] = corner_of(head.crn2);
        wgt[0] = head.wgt0;
        wgt[1] = head.wgt1;
        wgt[2] = head.wgt2;
    end

    // Weight times corner
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                px_reg[i] <= wgt[i] * crn[i].x;
                py_reg[i] <= wgt[i] * crn[i].y;
                pz_reg[i] <= wgt[i] * crn[i].z;
            end
            slot1_reg <= head.slot;
        end
    end

    // Blend sum, squares, squared length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side2_reg.slot  <= slot1_reg;
            side2_reg.vec_x <= VEC_W'(px_reg[0] + px_reg[1] + px_reg[2]);
            side2_reg.vec_y <= VEC_W'(py_reg[0] + py_reg[1] + py_reg[2]);
            side2_reg.vec_z <= VEC_W'(pz_reg[0] + pz_reg[1] + pz_reg[2]);

            side3_reg <= side2_reg;
            sqx_reg   <= SQ_W'(side2_reg.vec_x * side2_reg.vec_x);
            sqy_reg   <= SQ_W'(side2_reg.vec_y * side2_reg.vec_y);
            sqz_reg   <= SQ_W'(side2_reg.vec_z * side2_reg.vec_z);

            side4_reg  <= side3_reg;
            sum_sq_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    icv_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (vld4_reg),
        .sum_sq   (sum_sq_reg),
        .side_in  (side4_reg),
        .out_vld  (rt_vld),
        .root     (rt_root),
        .side_out (rt_side)
    );

    // Numerators: |w| * 2^FRAC_BITS + root/2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx_reg <= (NUM_W'(MAG_W'(rt_side.vec_x[VEC_W-1] ? -rt_side.vec_x
                                                               : rt_side.vec_x))
                         << FRAC_BITS) + NUM_W'(rt_root >> 1);
            numy_reg <= (NUM_W'(MAG_W'(rt_side.vec_y[VEC_W-1] ? -rt_side.vec_y
                                                               : rt_side.vec_y))
                         << FRAC_BITS) + NUM_W'(rt_root >> 1);
            numz_reg <= (NUM_W'(MAG_W'(rt_side.vec_z[VEC_W-1] ? -rt_side.vec_z
                                                               : rt_side.vec_z))
                         << FRAC_BITS) + NUM_W'(rt_root >> 1);
            den_reg   <= rt_root;
            neg_reg   <= {rt_side.vec_z[VEC_W-1], rt_side.vec_y[VEC_W-1],
                          rt_side.vec_x[VEC_W-1]};
            zero_reg  <= rt_root == '0;
            slot5_reg <= rt_side.slot;
        end
    end

    icv_div u_div_x (.clk(clk), .en(adv), .num(numx_reg), .den(den_reg), .quo(qx));
    icv_div u_div_y (.clk(clk), .en(adv), .num(numy_reg), .den(den_reg), .quo(qy));
    icv_div u_div_z (.clk(clk), .en(adv), .num(numz_reg), .den(den_reg), .quo(qz));

    // Sideband delay matching the dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dslot_reg[0] <= slot5_reg;
            dneg_reg[0]  <= neg_reg;
            dzero_reg[0] <= zero_reg;
            for (int i = 1; i < Q_W; i++)
            begin
                dslot_reg[i] <= dslot_reg[i-1];
                dneg_reg[i]  <= dneg_reg[i-1];
                dzero_reg[i] <= dzero_reg[i-1];
            end
        end
    end

    // Output data: sign, saturate, zero vector
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_slot_reg <= dslot_reg[Q_W-1];
            if (dzero_reg[Q_W-1])
            begin
                out_x_reg <= '0;
                out_y_reg <= '0;
                out_z_reg <= '0;
            end
            else
            begin
                out_x_reg <= scale_out(dneg_reg[Q_W-1][0], qx);
                out_y_reg <= scale_out(dneg_reg[Q_W-1][1], qy);
                out_z_reg <= scale_out(dneg_reg[Q_W-1][2], qz);
            end
        end
    end

    // Valid bits of the whole pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            vld5_reg    <= 1'b0;
            dvld_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg    <= pop;
            vld2_reg    <= vld1_reg;
            vld3_reg    <= vld2_reg;
            vld4_reg    <= vld3_reg;
            vld5_reg    <= rt_vld;
            dvld_reg    <= {dvld_reg[Q_W-2:0], vld5_reg};
            out_vld_reg <= dvld_reg[Q_W-1];
        end
    end

    assign vertex.valid       = out_vld_reg;
    assign vertex.vertex_slot = out_slot_reg;
    assign vertex.pos_x       = $signed(out_x_reg);
    assign vertex.pos_y       = $signed(out_y_reg);
    assign vertex.pos_z       = $signed(out_z_reg);

endmodule

/* tb/sv/icosphere_vertex_generator_test.sv */
// Testbench for the icosphere vertex generator: drives lattice points, predicts
// slot and unit-sphere position, checks every vertex. Depends on icv_pkg, icv_if.
module icosphere_vertex_generator_test;
    import icv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [STRIP_W-1:0] strip;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } point_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
    } vertex_t;

    localparam longint TIMEOUT_CYCLES = 2000000;
    localparam int     DRAIN_CYCLES   = 80;

    logic clk;
    logic rst_n;

    icv_cfg_if    cfg ();
    icv_point_if  point ();
    icv_vertex_if vertex ();

    icosphere_vertex_generator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.sink),
        .point  (point.source),
        .vertex (vertex.sink)
    );

    point_t  pending_points[$];
    vertex_t expected_vertices[$];
    int      cur_detail;
    int      fail_count = 0;
    longint  cycle_count = 0;
    bit      stall_enable;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Corner table, indexed by the package corner codes
    function automatic void corner_xyz(int code, output longint cx, output longint cy,
                                       output longint cz);
        longint o;
        longint p;
        o = 65536;
        p = 106039;
        case (code)
            CRN_RN0: begin cx = 0;  cy = -o; cz = p;  end
            CRN_RN1: begin cx = p;  cy = 0;  cz = o;  end
            CRN_RN2: begin cx = o;  cy = p;  cz = 0;  end
            CRN_RN3: begin cx = -o; cy = p;  cz = 0;  end
            CRN_RN4: begin cx = -p; cy = 0;  cz = o;  end
            CRN_RS0: begin cx = -o; cy = -p; cz = 0;  end
            CRN_RS1: begin cx = o;  cy = -p; cz = 0;  end
            CRN_RS2: begin cx = p;  cy = 0;  cz = -o; end
            CRN_RS3: begin cx = 0;  cy = o;  cz = -p; end
            CRN_RS4: begin cx = -p; cy = 0;  cz = -o; end
            CRN_PN:  begin cx = 0;  cy = o;  cz = p;  end
            default: begin cx = 0;  cy = -o; cz = -p; end
        endcase
    endfunction

    function automatic longint isqrt(longint unsigned s);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] norm_coord(longint w, longint r);
        longint unsigned mag;
        longint unsigned q;
        mag = (w < 0) ? -w : w;
        q = ((mag << FRAC_BITS) + (r >> 1)) / r;
        if (w < 0)
            return (q > 32768) ? 16'h8000 : POS_W'(-q);
        return (q > 32767) ? 16'h7FFF : POS_W'(q);
    endfunction

    // Expected vertex for one point under the current detail
    function automatic vertex_t predict_vertex(point_t pt);
        vertex_t v;
        int d, strip, nxt, col, row;
        int k0, k1, k2;
        longint c0, c1, c2, wx, wy, wz, ax, ay, az, bx, by, bz, ex, ey, ez, r;
        longint unsigned s;
        d = cur_detail;
        strip = pt.strip % 5;
        col = pt.col;
        row = pt.row;
        nxt = (strip + 1) % 5;
        v.slot = SLOT_W'(row + (3 * d + 1) * (col + d * strip));
        if (row >= 2 * d && col == 0)
        begin
            strip = (strip + 4) % 5;
            nxt = (nxt + 4) % 5;
            col = d;
        end
        if (row <= d)
        begin
            k0 = int'(CRN_RN0) + strip; k1 = int'(CRN_PN); k2 = int'(CRN_RN0) + nxt;
            c1 = d - row; c2 = col;
        end
        else if (row >= 2 * d)
        begin
            k0 = int'(CRN_RS0) + nxt; k1 = int'(CRN_PS); k2 = int'(CRN_RS0) + strip;
            c1 = row - 2 * d; c2 = d - col;
        end
        else if (row <= d + col)
        begin
            k0 = int'(CRN_RN0) + nxt; k1 = int'(CRN_RS0) + nxt; k2 = int'(CRN_RN0) + strip;
            c1 = row - d; c2 = d - col;
        end
        else
        begin
            k0 = int'(CRN_RS0) + strip; k1 = int'(CRN_RS0) + nxt;
            k2 = int'(CRN_RN0) + strip;
            c1 = col; c2 = 2 * d - row;
        end
        c0 = d - c1 - c2;
        corner_xyz(k0, ax, ay, az);
        corner_xyz(k1, bx, by, bz);
        corner_xyz(k2, ex, ey, ez);
        wx = c0 * ax + c1 * bx + c2 * ex;
        wy = c0 * ay + c1 * by + c2 * ey;
        wz = c0 * az + c1 * bz + c2 * ez;
        s = wx * wx + wy * wy + wz * wz;
        if (s == 0)
        begin
            v.x = '0; v.y = '0; v.z = '0;
        end
        else
        begin
            r = isqrt(s);
            v.x = norm_coord(wx, r);
            v.y = norm_coord(wy, r);
            v.z = norm_coord(wz, r);
        end
        return v;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Point handshake as seen at the rising edge
    bit point_taken;
    always @(posedge clk)
    begin
        point_taken <= (point.valid === 1'b1) && (point.ready === 1'b1);
    end

    // Point driver: inputs change on the falling edge
    int point_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            point.valid        <= 1'b0;
            point.strip_index  <= '0;
            point.column_index <= '0;
            point.row_index    <= '0;
            point_gap = 0;
        end
        else if (point.valid && !point_taken)
        begin
        end
        else
        begin
            if (point.valid)
                point_gap = stall_enable ? gap_len() : 0;
            if (point_gap > 0 || pending_points.size() == 0)
            begin
                if (point_gap > 0) point_gap--;
                point.valid <= 1'b0;
            end
            else
            begin
                point_t pt;
                pt = pending_points.pop_front();
                expected_vertices.push_back(predict_vertex(pt));
                point.strip_index  <= pt.strip;
                point.column_index <= pt.col;
                point.row_index    <= pt.row;
                point.valid        <= 1'b1;
            end
        end
    end

    // Vertex side back-pressure
    int ready_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            vertex.ready <= 1'b0;
            ready_gap = 0;
        end
        else if (ready_gap > 0)
        begin
            ready_gap--;
            vertex.ready <= 1'b0;
        end
        else
        begin
            if (stall_enable) ready_gap = gap_len();
            vertex.ready <= (ready_gap == 0);
        end
    end

    // Vertex monitor: sample at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && vertex.valid && vertex.ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                $error("vertex item with none expected");
                fail_count++;
            end
            else
            begin
                vertex_t e;
                e = expected_vertices.pop_front();
                if (vertex.vertex_slot !== e.slot)
                begin
                    $error("vertex_slot exp %0d got %0d", e.slot, vertex.vertex_slot);
                    fail_count++;
                end
                if (vertex.pos_x !== e.x)
                begin
                    $error("pos_x exp %0d got %0d", $signed(e.x), vertex.pos_x);
                    fail_count++;
                end
                if (vertex.pos_y !== e.y)
                begin
                    $error("pos_y exp %0d got %0d", $signed(e.y), vertex.pos_y);
                    fail_count++;
                end
                if (vertex.pos_z !== e.z)
                begin
                    $error("pos_z exp %0d got %0d", $signed(e.z), vertex.pos_z);
                    fail_count++;
                end
            end
        end
    end

    // Wait until every queued point has been taken and every vertex has come back
    task automatic drain_all();
        while (pending_points.size() != 0 || point.valid || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_detail(int d);
        @(negedge clk);
        cfg.detail <= DET_W'(d);
        cfg.valid  <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
        cur_detail = d;
    endtask

    function automatic void add_point(int s, int c, int r);
        point_t pt;
        pt.strip = STRIP_W'(s);
        pt.col = COL_W'(c);
        pt.row = ROW_W'(r);
        pending_points.push_back(pt);
    endfunction

    // Mostly in-range lattice points, some beyond range
    task automatic random_phase(int count);
        int d;
        d = cur_detail;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                add_point($urandom_range(0, 4), $urandom_range(0, d),
                          $urandom_range(0, 3 * d));
            else
                add_point($urandom_range(0, 7), $urandom_range(0, 127),
                          $urandom_range(0, 255));
        end
    endtask

    // Stimulus
    initial
    begin
        int d;
        stall_enable = 1'b1;
        cur_detail = 1;
        cfg.valid = 1'b0;
        cfg.detail = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset detail, corners of each region, column-0 move
        for (int s = 0; s < 5; s++) add_point(s, 0, 3);
        add_point(0, 1, 0);
        add_point(2, 1, 2);
        add_point(7, 127, 255);
        add_point(5, 0, 0);
        drain_all();

        write_detail(64);
        add_point(4, 64, 192);
        add_point(1, 0, 128);
        add_point(3, 32, 96);
        add_point(2, 10, 100);
        add_point(0, 64, 64);
        add_point(6, 0, 200);
        drain_all();

        // Detail zero: every point degenerates or extrapolates
        write_detail(0);
        add_point(0, 0, 0);
        add_point(3, 5, 7);
        add_point(7, 127, 255);
        drain_all();

        write_detail(127);
        add_point(4, 127, 255);
        add_point(2, 0, 254);
        drain_all();

        // Random phases over several detail settings
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: d = $urandom_range(1, 4);
                1: d = $urandom_range(5, 64);
                2: d = (ph == 2) ? 64 : 1;
                default: d = $urandom_range(0, 127);
            endcase
            write_detail(d);
            stall_enable = (ph % 3 != 1);
            random_phase(100);
            drain_all();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
